// File: rtl/sgc_pkg.sv
// ---------------------------------------------------------------------------
// sgc_pkg: shared types and constants for the session group counter
// address and session key types, fixed result field widths
// ---------------------------------------------------------------------------
package sgc_pkg;

  localparam int ADDR_W      = 32;
  localparam int SLOT_OUT_W  = 4;
  localparam int COUNT_OUT_W = 5;
  localparam int MSG_CNT_W   = 9;

  // largest value a per-session message count can hold
  localparam int MSG_CNT_CAP = (1 << MSG_CNT_W) - 1;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [MSG_CNT_W-1:0] msg_cnt_t;

  typedef struct packed {
    addr_t src;
    addr_t dst;
  } session_key_t;

endpackage

// File: rtl/sgc_lookup.sv
// ---------------------------------------------------------------------------
// sgc_lookup: parallel session table search
// compares one key against every stored session, lowest matching slot wins
// ---------------------------------------------------------------------------
module sgc_lookup #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4,
  parameter int USED_W  = 5
) (
  input  sgc_pkg::session_key_t keys [ENTRIES],
  input  logic [USED_W-1:0]     used,
  input  sgc_pkg::session_key_t query,
  output logic                  hit,
  output logic [IDX_W-1:0]      slot
);
  import sgc_pkg::*;

  logic [ENTRIES-1:0] match;

  // only entries below the fill count hold a session
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cmp
    assign match[k] = (USED_W'(k) < used) && (keys[k] == query);
  end

  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit  = 1'b1;
        slot = IDX_W'(k);
      end
    end
  end

endmodule

// File: rtl/session_group_counter_core.sv
// ---------------------------------------------------------------------------
// session_group_counter_core: distinct directed session counter
// counts distinct (source, destination) pairs in a message snapshot and
// tracks the busiest session
// ---------------------------------------------------------------------------
// The block takes one message per cycle while results are taken and returns
// one result transaction per message, in order. A message lands in an input
// register; from there a parallel compare against all stored sessions finds
// its slot, and when it advances the session table, fill count and running
// maximum are updated and the result register is loaded, so the next message
// sees the updated table with no gap. Result valid rises as the message
// leaves the input register; sustained rate is one message per cycle,
// limited only by the output side taking results. The session table holds
// MAX_SESSIONS pairs in order of first appearance; a new pair that finds the
// table full reports table_full with slot 0 and is not counted. Per-session
// counts saturate at MAX_QUEUE_DEPTH (never above 511). A message flagged
// last_in_snapshot reports the final totals, after which the table is empty
// again. Session entries carry no reset; only the fill count, running
// maximum and the two valid flags are cleared by rst.
// ---------------------------------------------------------------------------
module session_group_counter_core #(
  parameter int MAX_SESSIONS    = 16,
  parameter int MAX_QUEUE_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  // message channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sgc_pkg::addr_t                     source_ip,
  input  sgc_pkg::addr_t                     dest_ip,
  input  logic                               last_in_snapshot,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sgc_pkg::SLOT_OUT_W-1:0]     session_slot,
  output logic                               is_new_session,
  output logic                               table_full,
  output logic [sgc_pkg::COUNT_OUT_W-1:0]    session_count,
  output sgc_pkg::msg_cnt_t                  max_msgs_per_session,
  output logic                               is_last
);
  import sgc_pkg::*;

  localparam int IDX_W   = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
  localparam int USED_W  = $clog2(MAX_SESSIONS + 1);
  localparam int SLOT_WW = (IDX_W > SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;
  localparam int USED_WW = (USED_W > COUNT_OUT_W) ? USED_W : COUNT_OUT_W;
  localparam int LIMIT_I = (MAX_QUEUE_DEPTH < MSG_CNT_CAP) ? MAX_QUEUE_DEPTH : MSG_CNT_CAP;
  localparam msg_cnt_t COUNT_LIMIT = MSG_CNT_W'(LIMIT_I);
  localparam logic [USED_W-1:0] USED_MAX = USED_W'(MAX_SESSIONS);

  // input register
  logic         s1_valid;
  session_key_t s1_key;
  logic         s1_last;

  // session table, no reset: entries at or above the fill count are never read
  session_key_t keys      [MAX_SESSIONS];
  msg_cnt_t     msg_count [MAX_SESSIONS];
  logic [USED_W-1:0] used;
  msg_cnt_t          running_max;

  // lookup result
  logic             hit;
  logic [IDX_W-1:0] hit_slot;

  // update logic
  logic              advance;
  logic              store;
  logic              bump;
  logic [IDX_W-1:0]  res_slot;
  logic              res_new;
  logic              res_full;
  msg_cnt_t          cur_count;
  msg_cnt_t          inc_count;
  logic [USED_W-1:0] used_next;
  msg_cnt_t          running_max_next;
  logic [SLOT_WW-1:0] slot_wide;
  logic [USED_WW-1:0] used_wide;

  sgc_lookup #(
    .ENTRIES (MAX_SESSIONS),
    .IDX_W   (IDX_W),
    .USED_W  (USED_W)
  ) u_lookup (
    .keys  (keys),
    .used  (used),
    .query (s1_key),
    .hit   (hit),
    .slot  (hit_slot)
  );

  // the input register moves on when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_comb begin
    cur_count        = msg_count[hit_slot];
    inc_count        = (cur_count < COUNT_LIMIT) ? cur_count + 1'b1 : cur_count;
    store            = 1'b0;
    bump             = 1'b0;
    res_slot         = '0;
    res_new          = 1'b0;
    res_full         = 1'b0;
    used_next        = used;
    running_max_next = running_max;
    if (hit) begin
      // known session: count it and maybe raise the maximum
      bump     = 1'b1;
      res_slot = hit_slot;
      if (inc_count > running_max) begin
        running_max_next = inc_count;
      end
    end else begin
      res_new = 1'b1;
      if (used < USED_MAX) begin
        // new session takes the next free slot with a count of one
        store     = 1'b1;
        res_slot  = used[IDX_W-1:0];
        used_next = used + 1'b1;
        if (running_max == '0) begin
          running_max_next = msg_cnt_t'(1);
        end
      end else begin
        // table full: message dropped, slot reported as zero
        res_full = 1'b1;
      end
    end
    slot_wide = SLOT_WW'(res_slot);
    used_wide = USED_WW'(used_next);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      used        <= '0;
      running_max <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        // end of snapshot empties the table after its totals are reported
        if (s1_last) begin
          used        <= '0;
          running_max <= '0;
        end else begin
          used        <= used_next;
          running_max <= running_max_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_key.src <= source_ip;
      s1_key.dst <= dest_ip;
      s1_last    <= last_in_snapshot;
    end
    if (advance) begin
      if (store) begin
        keys[res_slot]      <= s1_key;
        msg_count[res_slot] <= msg_cnt_t'(1);
      end else if (bump) begin
        msg_count[hit_slot] <= inc_count;
      end
      session_slot         <= slot_wide[SLOT_OUT_W-1:0];
      is_new_session       <= res_new;
      table_full           <= res_full;
      session_count        <= used_wide[COUNT_OUT_W-1:0];
      max_msgs_per_session <= running_max_next;
      is_last              <= s1_last;
    end
  end

endmodule

// File: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: regression bench for session_group_counter_core
// streams message snapshots through the core under random backpressure and
// checks every result transaction against a cycle-free session table model
// ---------------------------------------------------------------------------
module tb_top;
  import sgc_pkg::*;

  // core configuration under test
  localparam int SESSIONS  = 16;
  localparam int QDEPTH    = 256;
  // per-session counts stop at the queue depth, never above the field cap
  localparam int CNT_LIMIT = (QDEPTH < MSG_CNT_CAP) ? QDEPTH : MSG_CNT_CAP;
  localparam int ITEMS     = 1850;
  localparam int MAX_SHOWN = 10;

  // one queued message as presented on the input channel
  typedef struct {
    addr_t src;
    addr_t dst;
    logic  last;
  } msg_t;

  // one result transaction, field by field
  typedef struct packed {
    logic [SLOT_OUT_W-1:0]  slot;
    logic                   is_new;
    logic                   full;
    logic [COUNT_OUT_W-1:0] count;
    msg_cnt_t               busiest;
    logic                   last;
  } session_res_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  addr_t                  source_ip;
  addr_t                  dest_ip;
  logic                   last_in_snapshot;
  logic                   out_valid;
  logic                   out_ready;
  logic [SLOT_OUT_W-1:0]  session_slot;
  logic                   is_new_session;
  logic                   table_full;
  logic [COUNT_OUT_W-1:0] session_count;
  msg_cnt_t               max_msgs_per_session;
  logic                   is_last;

  // messages waiting to be offered, and results the core still owes
  msg_t         msg_backlog[$];
  session_res_t session_results_due[$];

  int total_msgs;
  int n_accepted;
  int mismatches;
  bit in_taken;

  // model copy of the session table
  addr_t       tbl_src[SESSIONS];
  addr_t       tbl_dst[SESSIONS];
  int unsigned tbl_msgs[SESSIONS];
  int unsigned used_sessions;
  int unsigned busiest_count;

  // monitor scratch
  msg_t         seen_msg;
  session_res_t got_res;
  session_res_t want_res;

  session_group_counter_core #(
    .MAX_SESSIONS   (SESSIONS),
    .MAX_QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .source_ip           (source_ip),
    .dest_ip             (dest_ip),
    .last_in_snapshot    (last_in_snapshot),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .session_slot        (session_slot),
    .is_new_session      (is_new_session),
    .table_full          (table_full),
    .session_count       (session_count),
    .max_msgs_per_session(max_msgs_per_session),
    .is_last             (is_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // session table model: lookup, insert or count, then report totals
  // -------------------------------------------------------------------------
  function automatic session_res_t predict_session_result(msg_t m);
    session_res_t r;
    bit           hit;
    int unsigned  slot;
    hit  = 1'b0;
    slot = 0;
    // only slots already filled in this snapshot take part in the compare
    for (int k = 0; k < used_sessions; k++) begin
      if (!hit && tbl_src[k] == m.src && tbl_dst[k] == m.dst) begin
        hit  = 1'b1;
        slot = k;
      end
    end
    r.is_new = !hit;
    r.full   = 1'b0;
    if (hit) begin
      // known session: bump its count, saturating, and track the busiest
      if (tbl_msgs[slot] < CNT_LIMIT) tbl_msgs[slot]++;
      if (tbl_msgs[slot] > busiest_count) busiest_count = tbl_msgs[slot];
    end else if (used_sessions < SESSIONS) begin
      // new session takes the next free slot in first-appearance order
      slot           = used_sessions;
      tbl_src[slot]  = m.src;
      tbl_dst[slot]  = m.dst;
      tbl_msgs[slot] = 1;
      used_sessions++;
      if (busiest_count < 1) busiest_count = 1;
    end else begin
      // table full: flagged, fixed slot zero, nothing counted
      r.full = 1'b1;
      slot   = 0;
    end
    r.slot    = slot[SLOT_OUT_W-1:0];
    r.count   = used_sessions[COUNT_OUT_W-1:0];
    r.busiest = busiest_count[MSG_CNT_W-1:0];
    r.last    = m.last;
    // snapshot end: totals reported above, table empties afterwards
    if (m.last) begin
      used_sessions = 0;
      busiest_count = 0;
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------
  function automatic void push_msg(addr_t s, addr_t d, logic l);
    msg_t m;
    m.src  = s;
    m.dst  = d;
    m.last = l;
    msg_backlog.push_back(m);
  endfunction

  // one snapshot built from a small pool of related pairs, so that the
  // compare sees shared sources, shared destinations and reversed pairs
  task automatic add_snapshot();
    addr_t pool_src[$];
    addr_t pool_dst[$];
    int    kind;
    int    n_pool;
    int    len;
    int    idx;
    addr_t s;
    addr_t d;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        // noise: unrelated pairs only
        n_pool = 0;
        len    = $urandom_range(1, 20);
      end
      1, 2: begin
        // 14 to 24 pairs, often more than slots, can run into table full
        n_pool = $urandom_range(14, 24);
        len    = $urandom_range(20, 90);
      end
      default: begin
        n_pool = $urandom_range(1, 12);
        len    = $urandom_range(1, 40);
      end
    endcase
    for (int p = 0; p < n_pool; p++) begin
      idx = (p == 0) ? 0 : $urandom_range(0, p - 1);
      case ((p == 0) ? 0 : $urandom_range(0, 5))
        1: begin
          s = pool_src[idx];
          d = $urandom;
        end
        2: begin
          // same endpoints, opposite direction
          s = pool_dst[idx];
          d = pool_src[idx];
        end
        3: begin
          s = $urandom_range(0, 1) ? '1 : '0;
          d = $urandom_range(0, 1) ? '1 : '0;
        end
        4: begin
          s = $urandom;
          d = pool_dst[idx];
        end
        default: begin
          s = $urandom;
          d = $urandom;
        end
      endcase
      pool_src.push_back(s);
      pool_dst.push_back(d);
    end
    for (int i = 0; i < len; i++) begin
      if (n_pool == 0 || $urandom_range(0, 19) == 0) begin
        push_msg($urandom, $urandom, i == len - 1);
      end else begin
        idx = $urandom_range(0, n_pool - 1);
        push_msg(pool_src[idx], pool_dst[idx], i == len - 1);
      end
    end
  endtask

  // idle chance in percent: sender 16 / receiver 63 for the first third,
  // swapped for the second third, no idling for the rest
  function automatic int idle_pct(bit sender_side);
    if (n_accepted * 3 < total_msgs) return sender_side ? 16 : 63;
    if (n_accepted * 3 < total_msgs * 2) return sender_side ? 63 : 16;
    return 0;
  endfunction

  // -------------------------------------------------------------------------
  // driver: offers the next message at the falling edge once the previous
  // transaction went through, holding the payload while it waits
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (msg_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        in_valid         <= 1'b1;
        source_ip        <= msg_backlog[0].src;
        dest_ip          <= msg_backlog[0].dst;
        last_in_snapshot <= msg_backlog[0].last;
        void'(msg_backlog.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // -------------------------------------------------------------------------
  // monitor: predicts on each accepted message, checks each accepted result
  // against the oldest prediction
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen_msg.src  = source_ip;
        seen_msg.dst  = dest_ip;
        seen_msg.last = last_in_snapshot;
        session_results_due.push_back(predict_session_result(seen_msg));
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        got_res.slot    = session_slot;
        got_res.is_new  = is_new_session;
        got_res.full    = table_full;
        got_res.count   = session_count;
        got_res.busiest = max_msgs_per_session;
        got_res.last    = is_last;
        if (session_results_due.size() == 0) begin
          // result transaction with nothing outstanding
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result: slot=%0d new=%b full=%b count=%0d max=%0d last=%b",
                     got_res.slot, got_res.is_new, got_res.full, got_res.count,
                     got_res.busiest, got_res.last);
        end else begin
          want_res = session_results_due.pop_front();
          if (got_res.slot !== want_res.slot || got_res.is_new !== want_res.is_new ||
              got_res.full !== want_res.full || got_res.count !== want_res.count ||
              got_res.busiest !== want_res.busiest || got_res.last !== want_res.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("mismatch exp: slot=%0d new=%b full=%b count=%0d max=%0d last=%b",
                       want_res.slot, want_res.is_new, want_res.full, want_res.count,
                       want_res.busiest, want_res.last);
              $display("         act: slot=%0d new=%b full=%b count=%0d max=%0d last=%b",
                       got_res.slot, got_res.is_new, got_res.full, got_res.count,
                       got_res.busiest, got_res.last);
            end
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    addr_t sat_a;
    addr_t sat_b;
    rst              = 1'b1;
    in_valid         = 1'b0;
    out_ready        = 1'b0;
    source_ip        = '0;
    dest_ip          = '0;
    last_in_snapshot = 1'b0;
    in_taken         = 1'b0;
    n_accepted       = 0;
    mismatches       = 0;
    used_sessions    = 0;
    busiest_count    = 0;

    // address extremes, repeat hit, reversed direction, snapshot end
    push_msg('0, '0, 1'b0);
    push_msg('0, '0, 1'b0);
    push_msg('1, '1, 1'b0);
    push_msg('0, '1, 1'b0);
    push_msg('1, '0, 1'b0);
    push_msg('0, '0, 1'b1);
    // single message snapshot
    push_msg('0, '0, 1'b1);
    // fill all slots, one more new pair hits table full, then a known pair
    for (int k = 0; k < SESSIONS; k++) push_msg(addr_t'(k), ~addr_t'(k), 1'b0);
    push_msg(addr_t'(SESSIONS), ~addr_t'(SESSIONS), 1'b0);
    push_msg(addr_t'(3), ~addr_t'(3), 1'b1);

    // long snapshot dominated by one session to drive its count into saturation
    sat_a = $urandom;
    sat_b = $urandom;
    for (int i = 0; i < 300; i++) begin
      if (i % 30 == 7) push_msg(sat_b, sat_a, i == 299);
      else push_msg(sat_a, sat_b, i == 299);
    end

    // random snapshots
    while (msg_backlog.size() < ITEMS) add_snapshot();
    total_msgs = msg_backlog.size();

    // synchronous reset, released at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all messages offered and taken
    while (msg_backlog.size() != 0 || in_valid) @(posedge clk);
    // all results back, then a short drain for stray transactions
    while (session_results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("session_group_counter_core regression: pass");
    end else begin
      $display("session_group_counter_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("session_group_counter_core regression: fail");
    $finish;
  end

endmodule
